[hw/rtl/ssp_pkg.sv]
package ssp_pkg;

   localparam int PORT_W  = 16;
   localparam int ANGLE_W = 24;
   localparam int OFF_W   = 17;
   localparam int CSR_W   = 17;
   localparam int IDX_W   = 3;
   localparam int QUOT_W  = 22;

   localparam int TICK_RATE_HZ_DEF = 1000;

   localparam logic [PORT_W-1:0]  DEG180_Q8      = 16'd46080;
   localparam logic [ANGLE_W-1:0] DEG180_Q16     = 24'd11796480;
   localparam logic [ANGLE_W-1:0] DEG1_Q16       = 24'd65536;
   localparam logic [ANGLE_W-1:0] ANGLE_MAX      = 24'hFFFFFF;
   localparam logic [PORT_W-1:0]  START_ANGLE_RST = 16'd23040;
   localparam logic [PORT_W-1:0]  DUTY_MAX_RST   = 16'hFFFF;

   // 180 deg in Q8.16 is 45 * 2^18; divide by 45 as (q * RECIP45) >> RECIP45_SHIFT
   localparam int                 RECIP45_SHIFT = 28;
   localparam logic [22:0]        RECIP45       = 23'd5965233;

   typedef enum logic [1:0] {
      FUNC_JUMP = 2'd0,
      FUNC_RAMP = 2'd1,
      FUNC_TICK = 2'd2
   } func_type;

   typedef enum logic [IDX_W-1:0] {
      CSR_OFFSET_ANGLE  = 3'd0,
      CSR_INVERT_ENABLE = 3'd1,
      CSR_DUTY_MIN      = 3'd2,
      CSR_DUTY_MAX      = 3'd3,
      CSR_START_ANGLE   = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic signed [OFF_W-1:0] offset_angle;
      logic                    invert_enable;
      logic [PORT_W-1:0]       duty_min;
      logic [PORT_W-1:0]       duty_max;
   } cfg_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic               moving;
   } pos_type;

   typedef struct packed {
      logic [PORT_W-1:0] angle_now;
      logic              ramp_active;
   } track_type;

endpackage

[hw/rtl/ssp_if.sv]
interface ssp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [15:0] angle_in;
   logic [15:0] speed;

   modport source (output valid, output func, output angle_in, output speed, input ready);
   modport sink   (input valid, input func, input angle_in, input speed, output ready);
endinterface

interface ssp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] duty;
   logic [15:0] angle_now;
   logic        ramp_active;

   modport source (output valid, output duty, output angle_now, output ramp_active,
                   input ready);
   modport sink   (input valid, input duty, input angle_now, input ramp_active,
                   output ready);
endinterface

interface ssp_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [16:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/servo_slew_position_generator_top.sv]
// Throughput: one request per cycle unless the response side stalls; the command and angle
// update is registered in the state stage, and the duty mapping (clamp, multiply,
// divide-by-45 multiply, offset add) is a 4-stage pipe behind it.
// Reset: synchronous; clears the pipeline, sets the angle to 90 degrees, stops any ramp
// and loads register defaults (duty max 65535, others zero).
module servo_slew_position_generator_top #(
   parameter int TICK_RATE_HZ = ssp_pkg::TICK_RATE_HZ_DEF
) (
   input logic     clock,
   input logic     reset,
   ssp_req_if.sink   req_chan,
   ssp_rsp_if.source rsp_chan,
   ssp_csr_if.sink   csr_chan
);
   import ssp_pkg::*;

   cfg_type cfg;
   pos_type pos;
   logic    pos_valid;
   logic    pos_ready;

   ssp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   ssp_state #(
      .TICK_RATE_HZ (TICK_RATE_HZ)
   ) u_state (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .pos_valid (pos_valid),
      .pos_ready (pos_ready),
      .pos       (pos)
   );

   ssp_map u_map (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pos_valid (pos_valid),
      .pos_ready (pos_ready),
      .pos       (pos),
      .rsp_chan  (rsp_chan)
   );

endmodule

[hw/rtl/ssp_csr.sv]
module ssp_csr (
   input  logic             clock,
   input  logic             reset,
   ssp_csr_if.sink          csr_chan,
   output ssp_pkg::cfg_type cfg
);
   import ssp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg            = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_OFFSET_ANGLE:  cfg_in.offset_angle  = $signed(csr_chan.data[OFF_W-1:0]);
            CSR_INVERT_ENABLE: cfg_in.invert_enable = csr_chan.data[0];
            CSR_DUTY_MIN:      cfg_in.duty_min      = csr_chan.data[PORT_W-1:0];
            CSR_DUTY_MAX:      cfg_in.duty_max      = csr_chan.data[PORT_W-1:0];
            // start angle only matters at reset, where it is its reset value
            CSR_START_ANGLE:   cfg_in = cfg_ff;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_angle  <= '0;
         cfg_ff.invert_enable <= 1'b0;
         cfg_ff.duty_min      <= '0;
         cfg_ff.duty_max      <= DUTY_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/ssp_state.sv]
module ssp_state #(
   parameter int TICK_RATE_HZ = ssp_pkg::TICK_RATE_HZ_DEF
) (
   input  logic             clock,
   input  logic             reset,
   ssp_req_if.sink          req_chan,
   output logic             pos_valid,
   input  logic             pos_ready,
   output ssp_pkg::pos_type pos
);
   import ssp_pkg::*;

   // step = (speed << 8) / TICK_RATE_HZ via reciprocal, exact for dividends below 2^24
   localparam int          DivShift = ANGLE_W + $clog2(TICK_RATE_HZ);
   localparam logic [63:0] DivMult  =
      ((64'd1 << DivShift) + 64'(TICK_RATE_HZ) - 64'd1) / 64'(TICK_RATE_HZ);
   localparam int          MultW    = ANGLE_W + 1;
   localparam int          ProdW    = PORT_W + MultW + $clog2(TICK_RATE_HZ);

   logic [ANGLE_W-1:0] angle_ff, angle_in;
   logic [ANGLE_W-1:0] target_ff, target_in;
   logic [ANGLE_W-1:0] step_ff, step_in;
   logic               moving_ff, moving_in;
   logic               s1_valid_ff, s1_valid_in;
   pos_type            s1_ff, s1_in;

   logic               en1;
   logic               accept;
   logic [PORT_W-1:0]  tgt_q8;
   logic [ProdW-1:0]   step_prod;
   logic [ANGLE_W-1:0] diff;
   logic [ANGLE_W:0]   sum;

   assign en1            = !s1_valid_ff || pos_ready;
   assign req_chan.ready = en1;
   assign accept         = req_chan.valid && en1;
   assign pos_valid      = s1_valid_ff;
   assign pos            = s1_ff;

   assign tgt_q8    = (req_chan.angle_in > DEG180_Q8) ? DEG180_Q8 : req_chan.angle_in;
   assign step_prod = ProdW'(req_chan.speed) * ProdW'(DivMult[MultW-1:0]);
   assign diff      = (angle_ff > target_ff) ? angle_ff - target_ff : target_ff - angle_ff;
   assign sum       = {1'b0, angle_ff} + {1'b0, step_ff};

   always_comb begin
      angle_in  = angle_ff;
      target_in = target_ff;
      step_in   = step_ff;
      moving_in = moving_ff;
      case (req_chan.func)
         FUNC_JUMP: begin
            angle_in  = {req_chan.angle_in, 8'd0};
            moving_in = 1'b0;
         end
         FUNC_RAMP: begin
            target_in = {tgt_q8, 8'd0};
            step_in   = step_prod[DivShift-8 +: ANGLE_W];
            moving_in = 1'b1;
         end
         FUNC_TICK: begin
            if (moving_ff) begin
               if (diff <= DEG1_Q16) begin
                  moving_in = 1'b0;
               end else if (target_ff < angle_ff) begin
                  angle_in = (angle_ff > step_ff) ? angle_ff - step_ff : '0;
               end else begin
                  angle_in = sum[ANGLE_W] ? ANGLE_MAX : sum[ANGLE_W-1:0];
               end
            end
         end
         default: begin
            angle_in = angle_ff;
         end
      endcase
      s1_valid_in  = req_chan.valid;
      s1_in.angle  = angle_in;
      s1_in.moving = moving_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff    <= {START_ANGLE_RST, 8'd0};
         target_ff   <= '0;
         step_ff     <= '0;
         moving_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            angle_ff  <= angle_in;
            target_ff <= target_in;
            step_ff   <= step_in;
            moving_ff <= moving_in;
         end
         if (en1) begin
            s1_valid_ff <= s1_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff <= s1_in;
      end
   end

endmodule

[hw/rtl/ssp_map.sv]
module ssp_map (
   input  logic             clock,
   input  logic             reset,
   input  ssp_pkg::cfg_type cfg,
   input  logic             pos_valid,
   output logic             pos_ready,
   input  ssp_pkg::pos_type pos,
   ssp_rsp_if.source        rsp_chan
);
   import ssp_pkg::*;

   localparam int AdjW = ANGLE_W + 3;

   logic en2, en3, en4, en5;
   logic v2_ff, v3_ff, v4_ff, v5_ff;

   logic [ANGLE_W-1:0] a2_ff, a2_in;
   track_type          t2_ff, t3_ff, t4_ff;
   logic [QUOT_W-1:0]  q3_ff, q3_in;
   logic               neg3_ff, neg4_ff;
   logic [PORT_W-1:0]  quot4_ff, quot4_in;
   logic [PORT_W-1:0]  duty5_ff, duty5_in;
   track_type          t5_ff;

   logic signed [AdjW-1:0]   adj;
   logic signed [AdjW-1:0]   adj_inv;
   logic signed [PORT_W:0]   span;
   logic [PORT_W-1:0]        span_mag;
   logic [ANGLE_W+PORT_W-1:0] prod3;
   logic [QUOT_W+22:0]       prod4;
   track_type                t_new;

   assign en5       = !v5_ff || rsp_chan.ready;
   assign en4       = !v4_ff || en5;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign pos_ready = en2;

   assign t_new.angle_now   = pos.angle[ANGLE_W-1:8];
   assign t_new.ramp_active = pos.moving;

   // adjust, mirror, clamp to 0..180 degrees
   always_comb begin
      adj     = $signed({3'd0, pos.angle}) - $signed({{2{cfg.offset_angle[OFF_W-1]}},
                                                      cfg.offset_angle, 8'd0});
      adj_inv = cfg.invert_enable ? $signed({3'd0, DEG180_Q16}) - adj : adj;
      if (adj_inv < 0) begin
         a2_in = '0;
      end else if (adj_inv > $signed({3'd0, DEG180_Q16})) begin
         a2_in = DEG180_Q16;
      end else begin
         a2_in = adj_inv[ANGLE_W-1:0];
      end
   end

   // |a * span| >> 18, sign kept aside
   assign span     = $signed({1'b0, cfg.duty_max}) - $signed({1'b0, cfg.duty_min});
   assign span_mag = span[PORT_W] ? PORT_W'(-span) : span[PORT_W-1:0];
   assign prod3    = (ANGLE_W+PORT_W)'(a2_ff) * (ANGLE_W+PORT_W)'(span_mag);
   assign q3_in    = prod3[ANGLE_W+PORT_W-1:18];

   // divide by 45
   assign prod4    = (QUOT_W+23)'(q3_ff) * (QUOT_W+23)'(RECIP45);
   assign quot4_in = prod4[RECIP45_SHIFT +: PORT_W];

   assign duty5_in = neg4_ff ? cfg.duty_min - quot4_ff : cfg.duty_min + quot4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en2) v2_ff <= pos_valid;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         a2_ff <= a2_in;
         t2_ff <= t_new;
      end
      if (en3) begin
         q3_ff   <= q3_in;
         neg3_ff <= span[PORT_W];
         t3_ff   <= t2_ff;
      end
      if (en4) begin
         quot4_ff <= quot4_in;
         neg4_ff  <= neg3_ff;
         t4_ff    <= t3_ff;
      end
      if (en5) begin
         duty5_ff <= duty5_in;
         t5_ff    <= t4_ff;
      end
   end

   assign rsp_chan.valid       = v5_ff;
   assign rsp_chan.duty        = duty5_ff;
   assign rsp_chan.angle_now   = t5_ff.angle_now;
   assign rsp_chan.ramp_active = t5_ff.ramp_active;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import ssp_pkg::*;

   localparam int TICK_HZ      = TICK_RATE_HZ_DEF;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_LIMIT  = 20000;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [PORT_W-1:0] duty;
      logic [PORT_W-1:0] angle_now;
      logic              ramp_active;
   } servo_out_t;

   logic clock;
   logic reset;

   ssp_req_if req_bus ();
   ssp_rsp_if rsp_bus ();
   ssp_csr_if csr_bus ();

   servo_slew_position_generator_top #(.TICK_RATE_HZ(TICK_HZ)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   logic signed [OFF_W-1:0] cfg_offset;
   logic                    cfg_invert;
   logic [PORT_W-1:0]       cfg_duty_min;
   logic [PORT_W-1:0]       cfg_duty_max;
   logic [PORT_W-1:0]       cfg_start;

   logic [ANGLE_W-1:0] pos_angle;
   logic [ANGLE_W-1:0] pos_target;
   logic [ANGLE_W-1:0] pos_step;
   logic               pos_moving;

   servo_out_t expected_q[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   bit req_gaps_on = 1'b1;
   bit rsp_stalls_on = 1'b1;
   int rsp_hold_len = 0;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("servo_slew_position_generator_top regression: fail");
         $finish;
      end
   end

   function automatic void reset_servo_model();
      cfg_offset   = '0;
      cfg_invert   = 1'b0;
      cfg_duty_min = '0;
      cfg_duty_max = DUTY_MAX_RST;
      cfg_start    = START_ANGLE_RST;
      pos_angle    = {START_ANGLE_RST, 8'd0};
      pos_target   = '0;
      pos_step     = '0;
      pos_moving   = 1'b0;
   endfunction

   function automatic logic [PORT_W-1:0] mapped_duty();
      longint adj;
      longint span;
      longint level;
      adj = longint'(pos_angle) - longint'(cfg_offset) * 256;
      if (cfg_invert) adj = longint'(DEG180_Q16) - adj;
      if (adj < 0) adj = 0;
      if (adj > longint'(DEG180_Q16)) adj = longint'(DEG180_Q16);
      span  = longint'(cfg_duty_max) - longint'(cfg_duty_min);
      level = longint'(cfg_duty_min) + (adj * span) / longint'(DEG180_Q16);
      return level[PORT_W-1:0];
   endfunction

   function automatic void store_setting(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      case (idx)
         CSR_OFFSET_ANGLE:  cfg_offset   = signed'(data[OFF_W-1:0]);
         CSR_INVERT_ENABLE: cfg_invert   = data[0];
         CSR_DUTY_MIN:      cfg_duty_min = data[PORT_W-1:0];
         CSR_DUTY_MAX:      cfg_duty_max = data[PORT_W-1:0];
         CSR_START_ANGLE:   cfg_start    = data[PORT_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic void advance_servo(logic [1:0] func, logic [PORT_W-1:0] ang,
                                         logic [PORT_W-1:0] spd);
      logic [ANGLE_W-1:0] diff;
      logic [ANGLE_W:0]   sum;
      logic [PORT_W-1:0]  tgt;
      int unsigned        quot;
      servo_out_t         res;
      case (func)
         FUNC_JUMP: begin
            pos_angle  = {ang, 8'd0};
            pos_moving = 1'b0;
         end
         FUNC_RAMP: begin
            tgt        = (ang > DEG180_Q8) ? DEG180_Q8 : ang;
            pos_target = {tgt, 8'd0};
            quot       = (int'(spd) << 8) / TICK_HZ;
            pos_step   = quot[ANGLE_W-1:0];
            pos_moving = 1'b1;
         end
         FUNC_TICK: if (pos_moving) begin
            diff = (pos_angle > pos_target) ? pos_angle - pos_target : pos_target - pos_angle;
            if (diff <= DEG1_Q16) begin
               pos_moving = 1'b0;
            end else if (pos_target < pos_angle) begin
               pos_angle = (pos_angle > pos_step) ? pos_angle - pos_step : '0;
            end else begin
               sum       = {1'b0, pos_angle} + {1'b0, pos_step};
               pos_angle = (sum > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : sum[ANGLE_W-1:0];
            end
         end
         default: ;
      endcase
      res.duty        = mapped_duty();
      res.angle_now   = pos_angle[ANGLE_W-1:8];
      res.ramp_active = pos_moving;
      expected_q.push_back(res);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [PORT_W-1:0] pick_angle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return PORT_W'($urandom_range(0, DEG180_Q8));
      if (r < 95) return PORT_W'($urandom_range(DEG180_Q8 + 1, DEG180_Q8 + 2000));
      return PORT_W'($urandom);
   endfunction

   task automatic send_request(logic [1:0] func, logic [PORT_W-1:0] ang,
                               logic [PORT_W-1:0] spd);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.func     <= func;
      req_bus.angle_in <= ang;
      req_bus.speed    <= spd;
      do @(posedge clock); while (!req_bus.ready);
      advance_servo(func, ang, spd);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      store_setting(idx, data);
   endtask

   task automatic apply_settings(logic signed [OFF_W-1:0] offset, logic inv,
                                 logic [PORT_W-1:0] dmin, logic [PORT_W-1:0] dmax,
                                 logic [PORT_W-1:0] start);
      csr_write(CSR_OFFSET_ANGLE, offset);
      csr_write(CSR_INVERT_ENABLE, {{(CSR_W-1){1'b0}}, inv});
      csr_write(CSR_DUTY_MIN, {1'b0, dmin});
      csr_write(CSR_DUTY_MAX, {1'b0, dmax});
      csr_write(CSR_START_ANGLE, {1'b0, start});
      csr_bus.valid <= 1'b0;
   endtask

   // mostly jump / ramp / tick-until-settled sequences, some random noise
   task automatic run_random_burst(int n_items);
      int sent;
      int ticks;
      int goal;
      int extra;
      logic [PORT_W-1:0] from;
      logic [PORT_W-1:0] spd;
      logic [1:0] noise_func;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 9) < 7) begin
            from = pick_angle();
            send_request(FUNC_JUMP, from, PORT_W'($urandom));
            goal = int'(from) + int'($urandom_range(0, 3000)) - 1500;
            if (goal < 0) goal = 0;
            if (goal > int'(16'hFFFF)) goal = int'(16'hFFFF);
            spd = ($urandom_range(0, 7) == 0) ? PORT_W'($urandom_range(0, 300))
                                              : PORT_W'($urandom_range(24000, 65535));
            send_request(FUNC_RAMP, PORT_W'(goal), spd);
            ticks = 0;
            while (pos_moving && ticks < 120) begin
               send_request(FUNC_TICK, PORT_W'($urandom), PORT_W'($urandom));
               ticks++;
            end
            extra = $urandom_range(0, 2);
            repeat (extra) send_request(FUNC_TICK, PORT_W'($urandom), PORT_W'($urandom));
            sent += 2 + ticks + extra;
         end else begin
            noise_func = 2'($urandom);
            send_request(noise_func, PORT_W'($urandom), PORT_W'($urandom));
            sent++;
         end
      end
   endtask

   task automatic settings_phase(logic signed [OFF_W-1:0] offset, logic inv,
                                 logic [PORT_W-1:0] dmin, logic [PORT_W-1:0] dmax,
                                 logic [PORT_W-1:0] start, int n_items);
      wait_idle();
      apply_settings(offset, inv, dmin, dmax, start);
      run_random_burst(n_items);
      wait_idle();
   endtask

   task automatic test_reset_state();
      send_request(FUNC_TICK, 16'd0, 16'd0);
      send_request(FUNC_UNUSED, 16'd0, 16'd0);
      wait_idle();
   endtask

   task automatic test_directed_commands();
      send_request(FUNC_JUMP, 16'd0, 16'd0);
      send_request(FUNC_JUMP, DEG180_Q8, 16'd0);
      // above 180 loads unclamped
      send_request(FUNC_JUMP, 16'hFFFF, 16'hFFFF);
      send_request(FUNC_TICK, 16'hFFFF, 16'hFFFF);
      // target clamps to 180, angle walks down
      send_request(FUNC_RAMP, 16'hFFFF, 16'hFFFF);
      repeat (3) send_request(FUNC_TICK, 16'd0, 16'd0);
      // step truncates to zero
      send_request(FUNC_JUMP, 16'd0, 16'd0);
      send_request(FUNC_RAMP, DEG180_Q8, 16'd3);
      repeat (2) send_request(FUNC_TICK, 16'd0, 16'd0);
      // exactly one degree away: stops on first tick
      send_request(FUNC_JUMP, START_ANGLE_RST, 16'd0);
      send_request(FUNC_RAMP, START_ANGLE_RST + 16'd256, 16'hFFFF);
      repeat (2) send_request(FUNC_TICK, 16'd0, 16'd0);
      send_request(FUNC_RAMP, START_ANGLE_RST + 16'd257, 16'hFFFF);
      repeat (2) send_request(FUNC_TICK, 16'd0, 16'd0);
      send_request(FUNC_UNUSED, 16'hFFFF, 16'hFFFF);
      send_request(FUNC_RAMP, 16'd0, 16'd0);
      send_request(FUNC_TICK, 16'd0, 16'd0);
      wait_idle();
   endtask

   task automatic test_settings_sweep();
      settings_phase(17'sd0, 1'b0, 16'd0, 16'hFFFF, START_ANGLE_RST, 100);
      settings_phase(-17'sd46080, 1'b0, 16'd1000, 16'd2000, 16'd0, 100);
      settings_phase(17'sd46080, 1'b1, 16'hFFFF, 16'd0, DEG180_Q8, 100);
      settings_phase(17'sd0, 1'b1, 16'd0, 16'hFFFF, 16'hFFFF, 100);
      settings_phase(OFF_W'(int'($urandom_range(0, 92160)) - 46080), 1'($urandom),
                     16'd32768, 16'd32768, PORT_W'($urandom_range(0, DEG180_Q8)), 100);
      settings_phase(OFF_W'($urandom), 1'($urandom), PORT_W'($urandom),
                     PORT_W'($urandom), PORT_W'($urandom), 100);
      settings_phase(OFF_W'(int'($urandom_range(0, 92160)) - 46080), 1'($urandom),
                     PORT_W'($urandom), PORT_W'($urandom), PORT_W'($urandom), 100);
   endtask

   task automatic test_unused_registers();
      wait_idle();
      for (int i = int'(CSR_START_ANGLE) + 1; i < 2**IDX_W; i++)
         csr_write(IDX_W'(i), CSR_W'($urandom));
      csr_bus.valid <= 1'b0;
      run_random_burst(50);
      wait_idle();
   endtask

   // receiver holds off while requests keep coming, block must stall
   task automatic test_backpressure();
      req_gaps_on  = 1'b0;
      rsp_hold_len = HOLD_CYCLES;
      send_request(FUNC_JUMP, 16'd10000, 16'd0);
      send_request(FUNC_RAMP, 16'd12000, 16'hFFFF);
      repeat (38) send_request(FUNC_TICK, PORT_W'($urandom), PORT_W'($urandom));
      req_gaps_on = 1'b1;
      wait_idle();
   endtask

   task automatic test_random_traffic();
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      run_random_burst(70);
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      run_random_burst(70);
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b1;
      run_random_burst(35);
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b0;
      run_random_burst(35);
      rsp_stalls_on = 1'b1;
      req_gaps_on   = 1'b1;
   endtask

   initial begin : rsp_ready_driver
      int run_left;
      int hold;
      rsp_bus.ready <= 1'b0;
      run_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_len > 0) begin
            hold         = rsp_hold_len;
            rsp_hold_len = 0;
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
            run_left = 0;
         end else if (!rsp_stalls_on) begin
            rsp_bus.ready <= 1'b1;
         end else if (run_left > 0) begin
            run_left--;
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_bus.ready <= 1'b0;
            run_left = pick_gap();
         end else begin
            rsp_bus.ready <= 1'b1;
            run_left = $urandom_range(0, 11);
         end
      end
   end

   always @(posedge clock) begin : result_checker
      servo_out_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t unexpected result: duty %0d angle_now %0d ramp_active %0b",
                     $time, rsp_bus.duty, rsp_bus.angle_now, rsp_bus.ramp_active);
            mismatch_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_bus.duty !== want.duty) begin
               $display("%0t duty mismatch: expected %0d actual %0d",
                        $time, want.duty, rsp_bus.duty);
               mismatch_count++;
            end
            if (rsp_bus.angle_now !== want.angle_now) begin
               $display("%0t angle_now mismatch: expected %0d actual %0d",
                        $time, want.angle_now, rsp_bus.angle_now);
               mismatch_count++;
            end
            if (rsp_bus.ramp_active !== want.ramp_active) begin
               $display("%0t ramp_active mismatch: expected %0b actual %0b",
                        $time, want.ramp_active, rsp_bus.ramp_active);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : sequencer
      int spins;
      req_bus.valid    <= 1'b0;
      req_bus.func     <= FUNC_JUMP;
      req_bus.angle_in <= '0;
      req_bus.speed    <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.index    <= CSR_OFFSET_ANGLE;
      csr_bus.data     <= '0;
      reset            <= 1'b1;
      reset_servo_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_directed_commands();
      test_settings_sweep();
      test_unused_registers();
      test_backpressure();
      test_random_traffic();

      req_bus.valid <= 1'b0;
      spins = 0;
      while (expected_q.size() != 0 && spins < DRAIN_LIMIT) begin
         @(posedge clock);
         spins++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_q.size() == 0) begin
         $display("servo_slew_position_generator_top regression: pass");
      end else begin
         $display("servo_slew_position_generator_top regression: fail");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/ssp_pkg.sv
hw/rtl/ssp_if.sv
hw/rtl/ssp_csr.sv
hw/rtl/ssp_state.sv
hw/rtl/ssp_map.sv
hw/rtl/servo_slew_position_generator_top.sv
tb/testbench.sv
